// ===== design/bqf_pkg.sv =====
package bqf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;

  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  // Coefficient register indexes, also used to pick the multiplier operand.
  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_e;

  typedef enum logic [1:0] {
    COND_NONE = 2'd0,
    COND_IN   = 2'd1,
    COND_OUT  = 2'd2
  } cond_e;

  typedef enum logic [1:0] {
    SRC_IN = 2'd0,
    SRC_X  = 2'd1,
    SRC_YQ = 2'd2
  } mul_src_e;

  typedef enum logic [1:0] {
    A_ZERO = 2'd0,
    A_S1   = 2'd1,
    A_ACC  = 2'd2
  } alu_a_e;

  typedef enum logic {
    B_P  = 1'b0,
    B_S2 = 1'b1
  } alu_b_e;

  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_ACC  = 2'd1,
    DST_S1   = 2'd2,
    DST_S2   = 2'd3
  } dest_e;

  typedef struct packed {
    cond_e     cond;
    logic      mul_en;
    coef_sel_e mul_coef;
    mul_src_e  mul_src;
    alu_a_e    alu_a;
    alu_b_e    alu_b;
    logic      alu_sub;
    dest_e     dest;
    logic      round_en;
    logic      move_s1;
    logic      last;
  } ucode_t;

  typedef struct packed {
    logic   go;
    logic   load_x;
    ucode_t uc;
  } dp_ctrl_t;

  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_Y     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ROUND = 3'd2;
  localparam logic [STEP_W-1:0] STEP_HOLD  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FB1   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_ADDS2 = 3'd5;
  localparam logic [STEP_W-1:0] STEP_FB2   = 3'd6;

  localparam ucode_t UC_NOP = '{
    cond: COND_NONE, mul_en: 1'b0, mul_coef: COEF_B0, mul_src: SRC_X,
    alu_a: A_ZERO, alu_b: B_P, alu_sub: 1'b0, dest: DST_NONE,
    round_en: 1'b0, move_s1: 1'b0, last: 1'b0
  };

  // Microprogram. P is the product register, ACC the accumulator.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uc;
    uc = UC_NOP;
    case (step)
      STEP_IDLE: begin
        // Wait for a sample; P <= b0*x straight from the port.
        uc.cond     = COND_IN;
        uc.mul_en   = 1'b1;
        uc.mul_coef = COEF_B0;
        uc.mul_src  = SRC_IN;
      end
      STEP_Y: begin
        // ACC <= s1 + b0*x; P <= b1*x
        uc.alu_a    = A_S1;
        uc.dest     = DST_ACC;
        uc.mul_en   = 1'b1;
        uc.mul_coef = COEF_B1;
      end
      STEP_ROUND: begin
        // yq <= round(ACC); ACC <= b1*x; P <= b2*x
        uc.cond     = COND_OUT;
        uc.round_en = 1'b1;
        uc.dest     = DST_ACC;
        uc.mul_en   = 1'b1;
        uc.mul_coef = COEF_B2;
      end
      STEP_HOLD: begin
        // s1 is spent, so it parks b2*x; P <= a1*yq
        uc.dest     = DST_S1;
        uc.mul_en   = 1'b1;
        uc.mul_coef = COEF_A1;
        uc.mul_src  = SRC_YQ;
      end
      STEP_FB1: begin
        // ACC <= ACC - a1*yq; P <= a2*yq
        uc.alu_a    = A_ACC;
        uc.alu_sub  = 1'b1;
        uc.dest     = DST_ACC;
        uc.mul_en   = 1'b1;
        uc.mul_coef = COEF_A2;
        uc.mul_src  = SRC_YQ;
      end
      STEP_ADDS2: begin
        uc.alu_a = A_ACC;
        uc.alu_b = B_S2;
        uc.dest  = DST_ACC;
      end
      STEP_FB2: begin
        // s2 <= b2*x - a2*yq; s1 <= ACC
        uc.alu_a   = A_S1;
        uc.alu_sub = 1'b1;
        uc.dest    = DST_S2;
        uc.move_s1 = 1'b1;
        uc.last    = 1'b1;
      end
      default: begin
        uc.last = 1'b1;
      end
    endcase
    return uc;
  endfunction

endpackage

// ===== design/bqf_coef_regs.sv =====
module bqf_coef_regs
  import bqf_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                   cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]                  cfg_data_i,
  output logic [NUM_COEFS-1:0][COEF_WIDTH-1:0]   coef_o
);

  // b0 resets to 1.0 so that the filter passes samples straight through.
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 4);

  logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[COEF_B0] <= COEF_ONE;
      coef_q[COEF_B1] <= '0;
      coef_q[COEF_B2] <= '0;
      coef_q[COEF_A1] <= '0;
      coef_q[COEF_A2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        COEF_B0: coef_q[COEF_B0] <= cfg_data_i;
        COEF_B1: coef_q[COEF_B1] <= cfg_data_i;
        COEF_B2: coef_q[COEF_B2] <= cfg_data_i;
        COEF_A1: coef_q[COEF_A1] <= cfg_data_i;
        COEF_A2: coef_q[COEF_A2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== design/bqf_sequencer.sv =====
module bqf_sequencer
  import bqf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_ctrl_t ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  ucode_t            uc;
  logic              go;

  always_comb begin
    uc = ucode_rom(step_q);
    case (uc.cond)
      COND_IN:  go = in_valid_i;
      // The rounding step overwrites the output register, so it waits for a free slot.
      COND_OUT: go = !out_valid_q || out_ready_i;
      default:  go = 1'b1;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (go) begin
      step_d = uc.last ? STEP_IDLE : step_q + STEP_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (go && uc.round_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o    = (uc.cond == COND_IN);
  assign out_valid_o   = out_valid_q;
  assign ctrl_o.go     = go;
  assign ctrl_o.load_x = go && (uc.cond == COND_IN);
  assign ctrl_o.uc     = uc;

endmodule

// ===== design/bqf_datapath.sv =====
module bqf_datapath
  import bqf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dp_ctrl_t                             ctrl_i,
  input  logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_i,
  input  logic [SAMPLE_WIDTH-1:0]              sample_i,
  output logic [SAMPLE_WIDTH-1:0]              sample_o
);

  localparam int ST = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int OS = COEF_WIDTH - 4;
  localparam int SH = ST - OS;

  localparam logic signed [ST-1:0] ST_MAX = {1'b0, {(ST-1){1'b1}}};
  localparam logic signed [ST-1:0] ST_MIN = {1'b1, {(ST-1){1'b0}}};
  localparam logic [ST:0] RND_HALF = {{(ST+1-OS){1'b0}}, 1'b1, {(OS-1){1'b0}}};

  function automatic logic signed [ST-1:0] sat_st(input logic [ST:0] v);
    if (v[ST] != v[ST-1]) begin
      sat_st = v[ST] ? ST_MIN : ST_MAX;
    end else begin
      sat_st = v[ST-1:0];
    end
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] x_q, yq_q, yq_d;
  logic signed [ST-1:0]           p_q, acc_q, s1_q, s2_q;
  logic signed [COEF_WIDTH-1:0]   mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic signed [ST-1:0]           alu_a, alu_b, alu_res;
  logic [ST:0]                    alu_sum, rnd_sum;
  logic signed [ST-1:0]           rnd_t;
  logic [SH-1:0]                  rnd_sh;
  logic [4:0]                     rnd_top;

  always_comb begin
    case (ctrl_i.uc.mul_coef)
      COEF_B0: mul_a = coef_i[COEF_B0];
      COEF_B1: mul_a = coef_i[COEF_B1];
      COEF_B2: mul_a = coef_i[COEF_B2];
      COEF_A1: mul_a = coef_i[COEF_A1];
      COEF_A2: mul_a = coef_i[COEF_A2];
      default: mul_a = '0;
    endcase
    case (ctrl_i.uc.mul_src)
      SRC_IN:  mul_b = sample_i;
      SRC_X:   mul_b = x_q;
      SRC_YQ:  mul_b = yq_q;
      default: mul_b = '0;
    endcase
  end

  // One adder with saturation to the state width. Every product fits the state
  // format exactly, so the sum never needs more than one guard bit.
  always_comb begin
    case (ctrl_i.uc.alu_a)
      A_S1:    alu_a = s1_q;
      A_ACC:   alu_a = acc_q;
      default: alu_a = '0;
    endcase
    alu_b = (ctrl_i.uc.alu_b == B_S2) ? s2_q : p_q;
    if (ctrl_i.uc.alu_sub) begin
      alu_sum = {alu_a[ST-1], alu_a} - {alu_b[ST-1], alu_b};
    end else begin
      alu_sum = {alu_a[ST-1], alu_a} + {alu_b[ST-1], alu_b};
    end
    alu_res = sat_st(alu_sum);
  end

  // Round half up, drop the fraction bits, then clamp to the sample range.
  always_comb begin
    rnd_sum = {acc_q[ST-1], acc_q} + RND_HALF;
    rnd_t   = sat_st(rnd_sum);
    rnd_sh  = rnd_t[ST-1:OS];
    rnd_top = rnd_sh[SAMPLE_WIDTH+3:SAMPLE_WIDTH-1];
    if ((&rnd_top) || !(|rnd_top)) begin
      yq_d = rnd_sh[SAMPLE_WIDTH-1:0];
    end else begin
      yq_d = {rnd_top[4], {(SAMPLE_WIDTH-1){~rnd_top[4]}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x) begin
      x_q <= sample_i;
    end
    if (ctrl_i.go && ctrl_i.uc.mul_en) begin
      p_q <= mul_a * mul_b;
    end
    if (ctrl_i.go && ctrl_i.uc.dest == DST_ACC) begin
      acc_q <= alu_res;
    end
    if (ctrl_i.go && ctrl_i.uc.round_en) begin
      yq_q <= yq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (ctrl_i.go) begin
      if (ctrl_i.uc.move_s1) begin
        s1_q <= acc_q;
      end else if (ctrl_i.uc.dest == DST_S1) begin
        s1_q <= alu_res;
      end
      if (ctrl_i.uc.dest == DST_S2) begin
        s2_q <= alu_res;
      end
    end
  end

  assign sample_o = yq_q;

endmodule

// ===== design/biquad_iir_filter_unit.sv =====
// Second-order IIR section in transposed direct form II. Samples are signed
// Q1.23 and coefficients signed Q4.28 (written through the cfg port, index 0..4
// for b0, b1, b2, a1, a2; b0 resets to 1.0 for passthrough). The two state words
// are 56 bits wide and saturate; the output is rounded half up and saturated to
// the sample width, and that quantized output is what feeds back. One sample
// is accepted only once the previous one is through: a microcode program of
// seven steps drives one shared multiplier and one saturating adder, and a
// step is spent for each of the five products plus the state updates. The
// result passes the product register and the accumulator into the output
// register at the rounding step; if the previous result has not been taken by
// then, the program holds there until it is. Reset clears both state words.
module biquad_iir_filter_unit
  import bqf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]             cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // sample_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata   // sample_out
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coef;
  logic [SAMPLE_WIDTH-1:0]              sample_out;
  dp_ctrl_t                             dp_ctrl;

  bqf_coef_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_coef_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .coef_o    (coef)
  );

  bqf_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ctrl_o     (dp_ctrl)
  );

  bqf_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dp_ctrl),
    .coef_i  (coef),
    .sample_i(s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .sample_o(sample_out)
  );

  assign m_axis_tdata = TDATA_W'(sample_out);

  // The sample register loads exactly on an input transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctrl.load_x == (s_axis_tvalid && s_axis_tready))
    else $error("sample load does not match input transaction");

  // Only one sample is in flight: no acceptance in the cycle after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  // A completed rounding step always leaves a valid result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_ctrl.go && dp_ctrl.uc.round_en) |=> m_axis_tvalid)
    else $error("rounded result not presented");

endmodule
